### rtl/two_level_page_table_walker_top_assert.svh
// Assertion macros used by the page table walker sequencer.
// Each macro is clocked on clock and disabled while reset is high.
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_TOP_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TPW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpw assertion failed");

// Next-cycle implication.
`define TPW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpw assertion failed");

`endif

### rtl/tpw_pkg.sv
// ----------------------------------------------------------------------------
// tpw_pkg
// Types and constants for the two-level page table walker.
// ----------------------------------------------------------------------------
package tpw_pkg;

   localparam int PAGE_BYTES  = 32;
   localparam int OFFSET_BITS = 5;
   localparam int PHYS_BITS   = 12;
   localparam int VA_BITS     = 15;
   localparam int FRAME_BITS  = 7;
   localparam int VALID_BIT   = 7;

   // virtual address fields
   localparam int DIR_MSB = 14;
   localparam int DIR_LSB = 10;
   localparam int TAB_MSB = 9;
   localparam int TAB_LSB = 5;
   localparam int OFF_MSB = 4;

   localparam logic [PHYS_BITS-1:0] BASE_RESET = 12'h220;

   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DIR_FAULT = 2'd1;
   localparam logic [1:0] ST_TAB_FAULT = 2'd2;
   localparam logic [1:0] ST_WRITE     = 2'd3;

   // memory address source
   localparam logic [1:0] SEL_WRITE = 2'd0;
   localparam logic [1:0] SEL_DIR   = 2'd1;
   localparam logic [1:0] SEL_TAB   = 2'd2;
   localparam logic [1:0] SEL_DATA  = 2'd3;

   typedef struct packed {
      logic                   op;
      logic [PHYS_BITS-1:0]   write_address;
      logic [7:0]             write_data;
      logic [VA_BITS-1:0]     virtual_address;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [7:0]             directory_entry;
      logic [7:0]             table_entry;
      logic [PHYS_BITS-1:0]   physical_address;
      logic [7:0]             read_value;
   } rsp_type;

   typedef struct packed {
      logic       take_req;
      logic [1:0] mem_sel;
      logic       mem_rd;
      logic       mem_wr;
      logic       cap_pde;
      logic       cap_pte;
      logic       cap_val;
      logic       set_status;
      logic [1:0] status;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic req_write;
      logic entry_valid;
   } sts_type;

   // page number (0..255) reduced modulo the page count
   typedef logic [FRAME_BITS-1:0] wrap_table_type [256];

   function automatic wrap_table_type build_wrap_table(input int num_pages);
      wrap_table_type tbl;
      int             r;
      r = 0;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = FRAME_BITS'(r);
         r = (r + 1 == num_pages) ? 0 : r + 1;
      end
      return tbl;
   endfunction

endpackage

### rtl/two_level_page_table_walker_top.sv
// A write request writes memory in S_WRITE; a translation reads the directory, table and
// data entries in S_DIR, S_TAB and S_DATA (a fault on either entry skips to S_FIN) and
// captures the value in S_LAST; S_FIN loads the response once the response slot is free.
// One request at a time: a new one is taken the cycle after the response is loaded; a full
// walk makes three dependent reads of the single-port physical memory. Reset (synchronous):
// sequencer idle, no response pending, directory base 0x220; memory is not cleared.
// ----------------------------------------------------------------------------
// two_level_page_table_walker_top
// Two-level page table walker over a byte-wide physical memory.
// ----------------------------------------------------------------------------
module two_level_page_table_walker_top #(
   parameter int NUM_PAGES = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tpw_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tpw_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [tpw_pkg::PHYS_BITS-1:0]   csr_wr_data
);

   tpw_pkg::cmd_type cmd;
   tpw_pkg::sts_type sts;

   tpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tpw_dp #(
      .NUM_PAGES (NUM_PAGES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule

### rtl/tpw_dp.sv
// ----------------------------------------------------------------------------
// tpw_dp
// Walker datapath: physical memory, base register, entry capture, result reg.
// ----------------------------------------------------------------------------
module tpw_dp #(
   parameter int NUM_PAGES = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tpw_pkg::req_type                req_data,
   input  logic                            csr_wr_en,
   input  logic [tpw_pkg::PHYS_BITS-1:0]   csr_wr_data,
   input  tpw_pkg::cmd_type                cmd,
   output tpw_pkg::sts_type                sts,
   output tpw_pkg::rsp_type                rsp_data
);

   localparam int PageBits = $clog2(NUM_PAGES);
   localparam int AddrBits = PageBits + tpw_pkg::OFFSET_BITS;
   localparam int MemBytes = NUM_PAGES * tpw_pkg::PAGE_BYTES;
   localparam tpw_pkg::wrap_table_type WrapTable = tpw_pkg::build_wrap_table(NUM_PAGES);

   logic [7:0] mem [MemBytes];

   logic [tpw_pkg::PHYS_BITS-1:0] base_ff;
   logic [tpw_pkg::PHYS_BITS-1:0] waddr_ff;
   logic [7:0]                    wdata_ff;
   logic [tpw_pkg::VA_BITS-1:0]   va_ff;
   logic [7:0]                    rdata_ff;
   logic [7:0]                    pde_ff;
   logic [7:0]                    pte_ff;
   logic [7:0]                    val_ff;
   logic [1:0]                    status_ff;
   tpw_pkg::rsp_type              rsp_ff;
   tpw_pkg::rsp_type              rsp_in;

   logic [tpw_pkg::PHYS_BITS:0]   dir_sum;
   logic [PageBits-1:0]           dir_page;
   logic [PageBits-1:0]           frame_page;
   logic [PageBits-1:0]           wr_page;
   logic [AddrBits-1:0]           mem_addr;

   always_comb begin
      dir_sum    = {1'b0, base_ff}
                 + (tpw_pkg::PHYS_BITS + 1)'(va_ff[tpw_pkg::DIR_MSB:tpw_pkg::DIR_LSB]);
      dir_page   = WrapTable[dir_sum[tpw_pkg::PHYS_BITS:tpw_pkg::OFFSET_BITS]][PageBits-1:0];
      frame_page = WrapTable[{1'b0, rdata_ff[tpw_pkg::FRAME_BITS-1:0]}][PageBits-1:0];
      wr_page    = WrapTable[{1'b0, waddr_ff[tpw_pkg::PHYS_BITS-1:tpw_pkg::OFFSET_BITS]}]
                   [PageBits-1:0];
      case (cmd.mem_sel)
         tpw_pkg::SEL_DIR:  mem_addr = {dir_page, dir_sum[tpw_pkg::OFFSET_BITS-1:0]};
         tpw_pkg::SEL_TAB:  mem_addr = {frame_page,
                                        va_ff[tpw_pkg::TAB_MSB:tpw_pkg::TAB_LSB]};
         tpw_pkg::SEL_DATA: mem_addr = {frame_page, va_ff[tpw_pkg::OFF_MSB:0]};
         default:           mem_addr = {wr_page, waddr_ff[tpw_pkg::OFFSET_BITS-1:0]};
      endcase
   end

   // single-port byte memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[mem_addr] <= wdata_ff;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= tpw_pkg::BASE_RESET;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         waddr_ff <= req_data.write_address;
         wdata_ff <= req_data.write_data;
         va_ff    <= req_data.virtual_address;
         pde_ff   <= '0;
         pte_ff   <= '0;
         val_ff   <= '0;
      end else begin
         if (cmd.cap_pde) pde_ff <= rdata_ff;
         if (cmd.cap_pte) pte_ff <= rdata_ff;
         if (cmd.cap_val) val_ff <= rdata_ff;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in.status           = status_ff;
      rsp_in.directory_entry  = pde_ff;
      rsp_in.table_entry      = pte_ff;
      rsp_in.physical_address = (status_ff == tpw_pkg::ST_OK)
                              ? {pte_ff[tpw_pkg::FRAME_BITS-1:0], va_ff[tpw_pkg::OFF_MSB:0]}
                              : '0;
      rsp_in.read_value       = val_ff;
   end

   assign sts.req_write   = (req_data.op == tpw_pkg::OP_WRITE);
   assign sts.entry_valid = rdata_ff[tpw_pkg::VALID_BIT];
   assign rsp_data        = rsp_ff;

endmodule

### rtl/tpw_ctrl.sv
// ----------------------------------------------------------------------------
// tpw_ctrl
// Walk sequencer: memory writes, directory, table and data reads, result handoff.
// ----------------------------------------------------------------------------
`include "two_level_page_table_walker_top_assert.svh"

module tpw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tpw_pkg::sts_type  sts,
   output tpw_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_DIR   = 3'd2;
   localparam logic [2:0] S_TAB   = 3'd3;
   localparam logic [2:0] S_DATA  = 3'd4;
   localparam logic [2:0] S_LAST  = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd       = '0;
      cmd.status = tpw_pkg::ST_OK;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
            if (req_valid) begin
               state_in = sts.req_write ? S_WRITE : S_DIR;
            end
         end
         S_WRITE: begin
            cmd.mem_sel    = tpw_pkg::SEL_WRITE;
            cmd.mem_wr     = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = tpw_pkg::ST_WRITE;
            state_in       = S_FIN;
         end
         S_DIR: begin
            cmd.mem_sel = tpw_pkg::SEL_DIR;
            cmd.mem_rd  = 1'b1;
            state_in    = S_TAB;
         end
         S_TAB: begin
            // read data holds the directory entry
            cmd.cap_pde = 1'b1;
            if (!sts.entry_valid) begin
               cmd.set_status = 1'b1;
               cmd.status     = tpw_pkg::ST_DIR_FAULT;
               state_in       = S_FIN;
            end else begin
               cmd.mem_sel = tpw_pkg::SEL_TAB;
               cmd.mem_rd  = 1'b1;
               state_in    = S_DATA;
            end
         end
         S_DATA: begin
            cmd.cap_pte = 1'b1;
            if (!sts.entry_valid) begin
               cmd.set_status = 1'b1;
               cmd.status     = tpw_pkg::ST_TAB_FAULT;
               state_in       = S_FIN;
            end else begin
               cmd.mem_sel = tpw_pkg::SEL_DATA;
               cmd.mem_rd  = 1'b1;
               state_in    = S_LAST;
            end
         end
         S_LAST: begin
            cmd.cap_val    = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = tpw_pkg::ST_OK;
            state_in       = S_FIN;
         end
         S_FIN: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TPW_ASSERT_NOW(a_one_port_op, cmd.mem_wr, !cmd.mem_rd)
   `TPW_ASSERT_NOW(a_no_rsp_overwrite, cmd.load_rsp, !rsp_valid_ff || rsp_ready)
   `TPW_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, state_ff != S_IDLE)
   `TPW_ASSERT_NEXT(a_rsp_after_load, cmd.load_rsp, rsp_valid_ff)

endmodule

### bench/two_level_page_table_walker_top_tb.sv
// ----------------------------------------------------------------------------
// two_level_page_table_walker_top_tb
// Self-checking bench for the page table walker. Write requests build
// directory and table chains in memory, and translations run over several
// directory bases, the extremes among them. Each response is checked field
// by field against a walk done in the bench.
// ----------------------------------------------------------------------------
module two_level_page_table_walker_top_tb;

   localparam int NUM_PAGES      = 128;
   localparam int MEM_BYTES      = NUM_PAGES * tpw_pkg::PAGE_BYTES;
   localparam int PHASE_REQS     = 300;
   localparam int NUM_PHASES     = 6;
   localparam int IDLE_PCT       = 15;
   localparam int STALL_CYCLES   = 80;
   localparam int STALL_AT       = 150;
   localparam int QUIET_FROM     = 900;
   localparam int QUIET_TO       = 1150;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   tpw_pkg::req_type              req_data    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   tpw_pkg::rsp_type              rsp_data;
   logic                          csr_wr_en   = 1'b0;
   logic [tpw_pkg::PHYS_BITS-1:0] csr_wr_data = '0;

   tpw_pkg::req_type pending_reqs[$];
   tpw_pkg::rsp_type expected_rsps[$];
   tpw_pkg::rsp_type want_rsp;

   // memory and base as the block sees them, updated on each accepted request
   logic [7:0]                    phys_mem [MEM_BYTES];
   logic [tpw_pkg::PHYS_BITS-1:0] dir_base = tpw_pkg::BASE_RESET;

   // memory as it will be once all queued requests are done; keeps
   // translations away from bytes never written
   logic [7:0]                    plan_mem     [MEM_BYTES];
   bit                            plan_written [MEM_BYTES];
   logic [tpw_pkg::PHYS_BITS-1:0] plan_base = tpw_pkg::BASE_RESET;

   int  phase_reqs  = 0;
   int  rsp_count   = 0;
   int  errors      = 0;
   int  idle_cycles = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;

   two_level_page_table_walker_top #(
      .NUM_PAGES(NUM_PAGES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int frame_addr(input logic [tpw_pkg::FRAME_BITS-1:0] frame,
                                     input logic [tpw_pkg::OFFSET_BITS-1:0] idx);
      return (int'(frame) % NUM_PAGES) * tpw_pkg::PAGE_BYTES + int'(idx);
   endfunction

   function automatic int dir_addr(input logic [tpw_pkg::PHYS_BITS-1:0] base,
                                   input logic [tpw_pkg::VA_BITS-1:0] va);
      return (int'(base) + int'(va[tpw_pkg::DIR_MSB:tpw_pkg::DIR_LSB])) % MEM_BYTES;
   endfunction

   // expected response of one request; a write also updates the memory copy
   function automatic tpw_pkg::rsp_type walk_page_tables(input tpw_pkg::req_type r);
      tpw_pkg::rsp_type res;
      res = '0;
      if (r.op == tpw_pkg::OP_WRITE) begin
         phys_mem[int'(r.write_address) % MEM_BYTES] = r.write_data;
         res.status = tpw_pkg::ST_WRITE;
      end else begin
         res.directory_entry = phys_mem[dir_addr(dir_base, r.virtual_address)];
         if (!res.directory_entry[tpw_pkg::VALID_BIT]) begin
            res.status = tpw_pkg::ST_DIR_FAULT;
         end else begin
            res.table_entry = phys_mem[frame_addr(
               res.directory_entry[tpw_pkg::FRAME_BITS-1:0],
               r.virtual_address[tpw_pkg::TAB_MSB:tpw_pkg::TAB_LSB])];
            if (!res.table_entry[tpw_pkg::VALID_BIT]) begin
               res.status = tpw_pkg::ST_TAB_FAULT;
            end else begin
               res.physical_address = {res.table_entry[tpw_pkg::FRAME_BITS-1:0],
                                       r.virtual_address[tpw_pkg::OFF_MSB:0]};
               res.read_value = phys_mem[frame_addr(
                  res.table_entry[tpw_pkg::FRAME_BITS-1:0],
                  r.virtual_address[tpw_pkg::OFF_MSB:0])];
               res.status = tpw_pkg::ST_OK;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [7:0] random_entry();
      return {($urandom_range(3) != 0), (tpw_pkg::FRAME_BITS)'($urandom)};
   endfunction

   function automatic void queue_write(input int addr, input logic [7:0] value);
      tpw_pkg::req_type r;
      r.op              = tpw_pkg::OP_WRITE;
      r.write_address   = (tpw_pkg::PHYS_BITS)'(addr);
      r.write_data      = value;
      r.virtual_address = (tpw_pkg::VA_BITS)'($urandom);
      plan_mem[addr]     = value;
      plan_written[addr] = 1'b1;
      pending_reqs.push_back(r);
      phase_reqs++;
   endfunction

   function automatic void fill_if_unwritten(input int addr, input bit is_entry);
      if (!plan_written[addr])
         queue_write(addr, is_entry ? random_entry() : 8'($urandom));
   endfunction

   // translation, preceded by writes for any byte of its walk not yet written
   function automatic void queue_translate(input logic [tpw_pkg::VA_BITS-1:0] va);
      tpw_pkg::req_type r;
      int               a;
      a = dir_addr(plan_base, va);
      fill_if_unwritten(a, 1'b1);
      if (plan_mem[a][tpw_pkg::VALID_BIT]) begin
         a = frame_addr(plan_mem[a][tpw_pkg::FRAME_BITS-1:0],
                        va[tpw_pkg::TAB_MSB:tpw_pkg::TAB_LSB]);
         fill_if_unwritten(a, 1'b1);
         if (plan_mem[a][tpw_pkg::VALID_BIT])
            fill_if_unwritten(frame_addr(plan_mem[a][tpw_pkg::FRAME_BITS-1:0],
                                         va[tpw_pkg::OFF_MSB:0]), 1'b0);
      end
      r.op              = tpw_pkg::OP_TRANSLATE;
      r.write_address   = (tpw_pkg::PHYS_BITS)'($urandom);
      r.write_data      = 8'($urandom);
      r.virtual_address = va;
      pending_reqs.push_back(r);
      phase_reqs++;
   endfunction

   function automatic bit no_idle();
      return rsp_count >= QUIET_FROM && rsp_count < QUIET_TO;
   endfunction

   function automatic void check_field(input string name, input logic [11:0] want_v,
                                       input logic [11:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
         errors++;
      end
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver; the expected response is computed at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.push_back(walk_page_tables(req_data));
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && (no_idle() || $urandom_range(99) >= IDLE_PCT)) begin
               req_data  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready generation, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, actual %h", $time, rsp_data);
               errors++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               check_field("status", 12'(want_rsp.status), 12'(rsp_data.status));
               check_field("directory_entry", 12'(want_rsp.directory_entry),
                           12'(rsp_data.directory_entry));
               check_field("table_entry", 12'(want_rsp.table_entry),
                           12'(rsp_data.table_entry));
               check_field("physical_address", want_rsp.physical_address,
                           rsp_data.physical_address);
               check_field("read_value", 12'(want_rsp.read_value), 12'(rsp_data.read_value));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_count >= STALL_AT && rsp_valid) begin
            hold_done = 1'b1;
            hold_left = STALL_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle() || $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [tpw_pkg::PHYS_BITS-1:0] new_base;
      logic [tpw_pkg::VA_BITS-1:0]   va;
      int                            pick;
      int                            a;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            case (p)
               1:       new_base = '1;
               2:       new_base = '0;
               5:       new_base = tpw_pkg::BASE_RESET;
               default: new_base = (tpw_pkg::PHYS_BITS)'($urandom);
            endcase
            csr_wr_en   <= 1'b1;
            csr_wr_data <= new_base;
            @(posedge clock);
            csr_wr_en <= 1'b0;
            dir_base  = new_base;
            plan_base = new_base;
         end
         phase_reqs = 0;

         if (p == 0) begin
            queue_write(0, 8'hFF);
            queue_write(MEM_BYTES - 1, 8'h00);
            // directory fault on index 0
            queue_write(dir_addr(plan_base, '0), 8'h00);
            queue_translate('0);
            // table fault, then a walk ending at the last memory byte
            queue_write(dir_addr(plan_base, '1), 8'h85);
            queue_write(frame_addr(7'd5, '1), 8'h7F);
            queue_translate('1);
            queue_write(frame_addr(7'd5, '1), 8'hFF);
            queue_translate('1);
            // directory 1 points at frame 0, whose first entry names frame 127
            queue_write(dir_addr(plan_base, 15'h0400), 8'h80);
            queue_write(frame_addr(7'd127, '0), 8'hA5);
            queue_translate(15'h0400);
         end

         while (phase_reqs < PHASE_REQS) begin
            pick = $urandom_range(99);
            va   = (tpw_pkg::VA_BITS)'($urandom);
            if (pick < 60) begin
               queue_translate(va);
            end else if (pick < 80) begin
               // rewrite an entry on some walk, flipping faults and frames
               a = dir_addr(plan_base, va);
               if ($urandom_range(1) && plan_written[a] && plan_mem[a][tpw_pkg::VALID_BIT])
                  a = frame_addr(plan_mem[a][tpw_pkg::FRAME_BITS-1:0],
                                 va[tpw_pkg::TAB_MSB:tpw_pkg::TAB_LSB]);
               queue_write(a, random_entry());
            end else begin
               queue_write($urandom_range(MEM_BYTES - 1), 8'($urandom));
            end
         end
      end

      wait_idle();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/tpw_pkg.sv
rtl/tpw_dp.sv
rtl/tpw_ctrl.sv
rtl/two_level_page_table_walker_top.sv
bench/two_level_page_table_walker_top_tb.sv
